/* rtl/omf_record_deframer_macros.svh */
// ----------------------------------------------------------------------------
// omf_record_deframer assertion macros
// Concurrent checks sampled on clock; the plain form is masked during reset.
// ----------------------------------------------------------------------------
`ifndef OMF_RECORD_DEFRAMER_MACROS_SVH
`define OMF_RECORD_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// check prop at every clock edge outside reset
`define OMFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check prop at every clock edge, reset included
`define OMFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define OMFD_ASSERT(lbl, prop, msg)

`define OMFD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/omfd_pkg.sv */
// ----------------------------------------------------------------------------
// omfd_pkg
// Types and constants of the object record deframer.
// ----------------------------------------------------------------------------
package omfd_pkg;

   // width of the trailing byte counter (16 to 32)
   localparam int TRAIL_COUNT_WIDTH = 24;
   localparam int TRAIL_OUT_W       = 24;
   localparam logic [TRAIL_OUT_W-1:0] TRAIL_OUT_MAX = '1;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam int RSP_DATA_W = 72;

   // record type codes
   localparam logic [7:0] TYPE_LIBRARY  = 8'hf0;
   localparam logic [7:0] TYPE_DATA     = 8'ha0;
   localparam logic [7:0] TYPE_MODEND_A = 8'h8a;
   localparam logic [7:0] TYPE_MODEND_B = 8'h8b;

   // result kinds
   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic                   kind;
      logic [7:0]             rtype;
      logic [15:0]            rlength;
      logic                   bad;
      logic [15:0]            index;
      logic                   lib_seen;
      logic                   data_seen;
      logic [TRAIL_OUT_W-1:0] trail;
      logic                   trunc;
      logic                   last;
   } rsp_entry_type;

   function automatic logic [TRAIL_OUT_W-1:0] trail_clip(
      input logic [TRAIL_COUNT_WIDTH-1:0] cnt
   );
      logic [TRAIL_OUT_W-1:0] r;
      if (cnt > TRAIL_COUNT_WIDTH'(TRAIL_OUT_MAX)) begin
         r = TRAIL_OUT_MAX;
      end else begin
         r = TRAIL_OUT_W'(cnt);
      end
      return r;
   endfunction

endpackage

/* rtl/omf_record_deframer.sv */
// ----------------------------------------------------------------------------
// omf_record_deframer: object file record splitter and checker
// Takes one byte per cycle while not stalled; its results pass through the registered result queue.
// A byte closing a record at end of file gives two results, record then summary, queued together.
// Input stalls while the four-entry result queue holds more than two results.
// Synchronous reset clears parser state and queue at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "omf_record_deframer_macros.svh"

module omf_record_deframer
   import omfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_file

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] record_type, [23:8] record_length, [24] checksum_bad,
   // [40:25] record_index, [41] library_seen, [42] data_record_seen,
   // [66:43] trailing_bytes, [67] truncated, [71:68] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // result_kind
   output logic                  rsp_tlast    // last_result
);

   phase_type                    phase_ff, phase_in;
   logic [7:0]                   type_ff, type_in;
   logic [15:0]                  length_ff, length_in;
   logic [15:0]                  remain_ff, remain_in;
   logic [7:0]                   sum_ff, sum_in;
   logic                         lib_ff, lib_in;
   logic                         data_ff, data_in;
   logic [15:0]                  rec_cnt_ff, rec_cnt_in;
   logic [TRAIL_COUNT_WIDTH-1:0] trail_ff, trail_in;

   logic                         rec_done;
   logic                         trunc;
   logic                         push;
   logic                         pop;
   logic [1:0]                   n_wr;
   logic                         restarted;
   logic                         in_done;

   rsp_entry_type                rec_entry;
   rsp_entry_type                sum_entry;
   rsp_entry_type                head;
   rsp_entry_type                queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W-1:0]         wr_ptr_nxt;
   logic [RSP_CNT_W-1:0]         count_ff, count_in;

   assign req_tready = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // Parser next state for the byte on the input
   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      remain_in  = remain_ff;
      sum_in     = sum_ff;
      lib_in     = lib_ff;
      data_in    = data_ff;
      rec_cnt_in = rec_cnt_ff;
      trail_in   = trail_ff;
      rec_done   = 1'b0;

      unique case (phase_ff)
         PH_TYPE: begin
            type_in  = req_tdata;
            sum_in   = req_tdata;
            if (req_tdata == TYPE_LIBRARY) begin
               lib_in = 1'b1;
            end
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'h00, req_tdata};
            sum_in    = sum_ff + req_tdata;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {req_tdata, length_ff[7:0]};
            sum_in    = sum_ff + req_tdata;
            remain_in = {req_tdata, length_ff[7:0]};
            if ({req_tdata, length_ff[7:0]} == 16'h0000) begin
               rec_done = 1'b1;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            sum_in    = sum_ff + req_tdata;
            remain_in = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               rec_done = 1'b1;
            end
         end
         PH_DONE: begin
            if (trail_ff != '1) begin
               trail_in = trail_ff + TRAIL_COUNT_WIDTH'(1);
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase

      if (rec_done) begin
         if (type_in == TYPE_DATA) begin
            data_in = 1'b1;
         end
         if (rec_cnt_ff != 16'hffff) begin
            rec_cnt_in = rec_cnt_ff + 16'd1;
         end
         if (type_in == TYPE_MODEND_A || type_in == TYPE_MODEND_B) begin
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_TYPE;
         end
      end

      trunc = (phase_in != PH_TYPE) && (phase_in != PH_DONE);
   end

   // Result entries for the byte on the input
   always_comb begin
      rec_entry.kind      = KIND_RECORD;
      rec_entry.rtype     = type_in;
      rec_entry.rlength   = length_in;
      rec_entry.bad       = !lib_in && (sum_in != 8'h00);
      rec_entry.index     = rec_cnt_ff;
      rec_entry.lib_seen  = lib_in;
      rec_entry.data_seen = data_in;
      rec_entry.trail     = '0;
      rec_entry.trunc     = 1'b0;
      rec_entry.last      = !req_tlast;

      sum_entry.kind      = KIND_SUMMARY;
      sum_entry.rtype     = 8'h00;
      sum_entry.rlength   = 16'h0000;
      sum_entry.bad       = 1'b0;
      sum_entry.index     = rec_cnt_in;
      sum_entry.lib_seen  = lib_in;
      sum_entry.data_seen = data_in;
      sum_entry.trail     = trail_clip(trail_in);
      sum_entry.trunc     = trunc;
      sum_entry.last      = 1'b1;
   end

   assign n_wr       = push ? (2'(rec_done) + 2'(req_tlast)) : 2'd0;
   assign wr_ptr_nxt = wr_ptr_ff + RSP_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + RSP_PTR_W'(n_wr);
   assign rd_ptr_in  = pop ? (rd_ptr_ff + RSP_PTR_W'(1)) : rd_ptr_ff;
   assign count_in   = count_ff + RSP_CNT_W'(n_wr) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         lib_ff     <= 1'b0;
         data_ff    <= 1'b0;
         rec_cnt_ff <= '0;
         trail_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (push) begin
            if (req_tlast) begin
               // end of file: start the next file from scratch
               phase_ff   <= PH_TYPE;
               lib_ff     <= 1'b0;
               data_ff    <= 1'b0;
               rec_cnt_ff <= '0;
               trail_ff   <= '0;
            end else begin
               phase_ff   <= phase_in;
               lib_ff     <= lib_in;
               data_ff    <= data_in;
               rec_cnt_ff <= rec_cnt_in;
               trail_ff   <= trail_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         type_ff   <= type_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
         if (rec_done) begin
            queue_ff[wr_ptr_ff] <= rec_entry;
            if (req_tlast) begin
               queue_ff[wr_ptr_nxt] <= sum_entry;
            end
         end else if (req_tlast) begin
            queue_ff[wr_ptr_ff] <= sum_entry;
         end
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {4'h0, head.trunc, head.trail, head.data_seen, head.lib_seen,
                        head.index, head.bad, head.rlength, head.rtype};

   assign restarted = (phase_ff == PH_TYPE) && (rec_cnt_ff == '0) && (trail_ff == '0);
   assign in_done   = (phase_ff == PH_DONE);

   `OMFD_ASSERT_ALWAYS(a_queue_bound, reset || count_ff <= RSP_CNT_W'(RSP_DEPTH), "overflow")
   `OMFD_ASSERT(a_pair_together, (pop && !rsp_tlast) |-> count_ff >= RSP_CNT_W'(2), "lost summary")
   `OMFD_ASSERT(a_eof_restart, (push && req_tlast) |=> restarted, "no restart after end of file")
   `OMFD_ASSERT(a_done_sticks, (push && !req_tlast && in_done) |=> in_done, "left done phase")

endmodule
